// ----- rtl/bdc_pkg.sv -----
// ----------------------------------------------------------------------------
// bdc_pkg: shared types and constants for the bezier evaluator
// Point type, opcodes and cell control struct used by the cell row and top.
// ----------------------------------------------------------------------------
`default_nettype none
package bdc_pkg;
  localparam int COORD_W = 32;
  localparam int CNT_W   = 5;

  // request opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  // control broadcast to every cell
  typedef struct packed {
    logic copy;   // take control point into working register
    logic step;   // interpolate with right neighbor
  } cell_ctl_t;
endpackage
`default_nettype wire

// ----- rtl/bezier_de_casteljau_eval.sv -----
// ----------------------------------------------------------------------------
// bezier_de_casteljau_eval: 3d bezier curve point by de casteljau
// A load request writes one control point. An evaluate request with n points
// in use copies the control points into the row, then runs n-1 interpolation
// levels, one per cycle, all cells of the row working in parallel, before
// the strobe; busy is high meanwhile. The result is shown for one cycle on
// done and must be taken then: there is no back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none
module bezier_de_casteljau_eval import bdc_pkg::*; #(
  parameter int MAX_POINTS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic                     cfg_we,
  input  wire logic [CNT_W-1:0]         cfg_data,
  input  wire logic                     opcode,
  input  wire logic [3:0]               point_index,
  input  wire logic signed [COORD_W-1:0] coord_x,
  input  wire logic signed [COORD_W-1:0] coord_y,
  input  wire logic signed [COORD_W-1:0] coord_z,
  input  wire logic [FRAC_BITS:0]       param_t,
  output logic                          done,
  output logic signed [COORD_W-1:0]     out_x,
  output logic signed [COORD_W-1:0]     out_y,
  output logic signed [COORD_W-1:0]     out_z
);
  localparam int IW = $clog2(MAX_POINTS);
  localparam int LW = $clog2(MAX_POINTS + 1);
  localparam logic [FRAC_BITS:0] T_ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_COPY = 3'b010,
    S_STEP = 3'b100
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  point_count;
  logic [LW-1:0]     levels;
  logic [FRAC_BITS:0] t_reg;
  point_t            ctrl_pts [MAX_POINTS];
  point_t            work     [MAX_POINTS];
  point_t            right    [MAX_POINTS];
  cell_ctl_t         ctl;
  logic [LW-1:0]     n_eff;

  assign busy = (state != S_IDLE);
  assign ctl.copy = (state == S_COPY);
  assign ctl.step = (state == S_STEP);

  // clamp point count to one..max
  always_comb begin
    if (point_count == '0) begin
      n_eff = LW'(1);
    end else if (32'(point_count) > MAX_POINTS) begin
      n_eff = LW'(MAX_POINTS);
    end else begin
      n_eff = LW'(point_count);
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= CNT_W'(4);
    end else if (cfg_we) begin
      point_count <= cfg_data;
    end
  end

  // control point store written by load requests
  always_ff @(posedge clk) begin
    if (start && !busy && opcode == OP_LOAD && 32'(point_index) < MAX_POINTS) begin
      ctrl_pts[IW'(point_index)] <= '{x: coord_x, y: coord_y, z: coord_z};
    end
  end

  // sequencer: copy, then one level per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start && opcode == OP_EVAL) begin
            state  <= S_COPY;
          end
        end
        S_COPY: begin
          levels <= n_eff - LW'(1);
          state  <= S_STEP;
        end
        S_STEP: begin
          if (levels == '0) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end else begin
            levels <= levels - LW'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // saturated parameter
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      t_reg <= (param_t > T_ONE) ? T_ONE : param_t;
    end
  end

  // row of cells, each steps toward its right neighbor
  genvar g;
  generate
    for (g = 0; g < MAX_POINTS; g++) begin : g_cell
      if (g == MAX_POINTS - 1) begin : g_last
        assign right[g] = work[g];
      end else begin : g_mid
        assign right[g] = work[g+1];
      end
      bdc_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
        .clk    (clk),
        .ctl    (ctl),
        .enable (levels != '0),
        .t      (t_reg),
        .ctrl_pt(ctrl_pts[g]),
        .right  (right[g]),
        .work   (work[g])
      );
    end
  endgenerate

  assign out_x = work[0].x;
  assign out_y = work[0].y;
  assign out_z = work[0].z;
endmodule
`default_nettype wire

// ----- rtl/bdc_lerp.sv -----
// ----------------------------------------------------------------------------
// bdc_lerp: one coordinate interpolation
// p + round_half_up((q-p)*t >> frac_bits), combinational, one 33x17 product.
// ----------------------------------------------------------------------------
`default_nettype none
module bdc_lerp import bdc_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic signed [COORD_W-1:0] p,
  input  wire logic signed [COORD_W-1:0] q,
  input  wire logic        [FRAC_BITS:0] t,
  output logic signed [COORD_W-1:0]      r
);
  localparam int PW = COORD_W + FRAC_BITS + 3;
  logic signed [COORD_W:0]   d;
  logic signed [PW-1:0]      prod;
  logic signed [PW-1:0]      rnd;

  // difference, product, rounding half up (add half, then arithmetic shift)
  always_comb begin
    d    = {q[COORD_W-1], q} - {p[COORD_W-1], p};
    prod = PW'(d) * $signed({2'b0, t});
    rnd  = (prod + (PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    r    = p + rnd[COORD_W-1:0];
  end
endmodule
`default_nettype wire

// ----- rtl/bdc_cell.sv -----
// ----------------------------------------------------------------------------
// bdc_cell: one working point of the de casteljau row
// Holds one point; on copy it takes its control point, on an enabled step the lerp toward its right neighbor.
// ----------------------------------------------------------------------------
`default_nettype none
module bdc_cell import bdc_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic             clk,
  input  wire cell_ctl_t        ctl,
  input  wire logic             enable,
  input  wire logic [FRAC_BITS:0] t,
  input  wire point_t           ctrl_pt,
  input  wire point_t           right,
  output point_t                work
);
  point_t lerp_pt;

  bdc_lerp #(.FRAC_BITS(FRAC_BITS)) u_lx (.p(work.x), .q(right.x), .t(t), .r(lerp_pt.x));
  bdc_lerp #(.FRAC_BITS(FRAC_BITS)) u_ly (.p(work.y), .q(right.y), .t(t), .r(lerp_pt.y));
  bdc_lerp #(.FRAC_BITS(FRAC_BITS)) u_lz (.p(work.z), .q(right.z), .t(t), .r(lerp_pt.z));

  // working point register
  always_ff @(posedge clk) begin
    if (ctl.copy) begin
      work <= ctrl_pt;
    end else if (ctl.step && enable) begin
      work <= lerp_pt;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/bdc_checker.sv -----
// ----------------------------------------------------------------------------
// bdc_checker: port-level checks for the bezier evaluator
// Watches busy, done and start over time.
// ----------------------------------------------------------------------------
`default_nettype none
module bdc_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic opcode,
  input wire logic done
);
  // result only at the end of a busy period
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("done without busy");
  // busy drops exactly when result appears
  a_fall_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done) else $error("busy fell without result");
  // a load never makes the block busy
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !opcode) |=> !busy) else $error("load set busy");
  // an evaluate always makes it busy
  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode) |=> busy) else $error("eval not taken");
endmodule

bind bezier_de_casteljau_eval bdc_checker u_bdc_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode), .done(done)
);
`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench for bezier_de_casteljau_eval
// Loads control points and evaluates curves at a spread of t values under
// several point counts. A queue-fed driver issues requests and a monitor
// checks each strobed point against a de casteljau curve predictor.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bdc_pkg::*;

  localparam int SLOTS = 16;
  localparam int SETTLE_CYCLES = 24;

  typedef enum logic [1:0] {K_REQ, K_DRAIN, K_CFG} kind_e;

  typedef struct {
    kind_e       kind;
    logic        op;
    logic [3:0]  idx;
    point_t      pt;
    logic [16:0] t;
    logic [4:0]  cnt;
  } job_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic cfg_we = 1'b0;
  logic [4:0] cfg_data = '0;
  logic opcode = 1'b0;
  logic [3:0] point_index = '0;
  logic signed [31:0] coord_x = '0, coord_y = '0, coord_z = '0;
  logic [16:0] param_t = '0;
  logic busy, done;
  logic signed [31:0] out_x, out_y, out_z;

  job_t   job_q[$];
  job_t   cur_job;
  point_t curve_q[$];
  point_t ctrl_pts[SLOTS];
  int     pt_count = 4;
  int     issued = 0;
  int     total_reqs = 0;
  int     settle = 0;
  int     mismatches = 0;
  bit     fill_done = 0;

  bezier_de_casteljau_eval u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .opcode(opcode), .point_index(point_index),
    .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .param_t(param_t), .done(done),
    .out_x(out_x), .out_y(out_y), .out_z(out_z)
  );

  // clock and reset
  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  // one interpolation step, rounded half up
  function automatic logic signed [31:0] lerp_q16(logic signed [31:0] p,
                                                 logic signed [31:0] q, longint t);
    longint d;
    longint r;
    d = longint'(q) - longint'(p);
    r = (d * t + 64'sd32768) >>> 16;
    return 32'(longint'(p) + r);
  endfunction

  // curve point for the current point count
  function automatic point_t eval_curve(logic [16:0] tp);
    point_t w[SLOTS];
    int n;
    longint t;
    n = (pt_count == 0) ? 1 : (pt_count > SLOTS ? SLOTS : pt_count);
    t = (tp > 17'd65536) ? 65536 : longint'(tp);
    for (int i = 0; i < n; i++) w[i] = ctrl_pts[i];
    for (int lv = 1; lv < n; lv++)
      for (int i = 0; i + lv < n; i++) begin
        w[i].x = lerp_q16(w[i].x, w[i+1].x, t);
        w[i].y = lerp_q16(w[i].y, w[i+1].y, t);
        w[i].z = lerp_q16(w[i].z, w[i+1].z, t);
      end
    return w[0];
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'($urandom_range(0, 131072)) - 32'sd65536;
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic logic [16:0] rand_t();
    case ($urandom_range(0, 15))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'd32768;
      3: return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic add_load(int idx, logic signed [31:0] x, logic signed [31:0] y,
                          logic signed [31:0] z);
    job_t j;
    j = '{kind: K_REQ, op: OP_LOAD, idx: 4'(idx), pt: '{x, y, z}, t: 17'($urandom()),
          cnt: '0};
    job_q = {job_q, j};
    total_reqs++;
  endtask

  task automatic add_eval(logic [16:0] t);
    job_t j;
    j = '{kind: K_REQ, op: OP_EVAL, idx: 4'($urandom()),
          pt: '{$signed($urandom()), $signed($urandom()), $signed($urandom())},
          t: t, cnt: '0};
    job_q = {job_q, j};
    total_reqs++;
  endtask

  task automatic add_cfg(int c);
    job_t j;
    j = '{kind: K_DRAIN, op: OP_LOAD, idx: '0, pt: '{0, 0, 0}, t: '0, cnt: '0};
    job_q = {job_q, j};
    j.kind = K_CFG;
    j.cnt = 5'(c);
    job_q = {job_q, j};
  endtask

  // stimulus
  initial begin
    int cfgs[6] = '{16, 1, 0, 31, 17, 2};
    // fill every slot first so no evaluate reads an unwritten entry
    for (int i = 0; i < SLOTS; i++)
      add_load(i, (i % 2) ? 32'sh7fffffff : 32'sh80000000,
               (i % 3) ? 32'sh80000000 : 32'sh7fffffff, rand_coord());
    add_eval(17'd0);
    add_eval(17'd65536);
    add_eval(17'd32768);
    add_eval(17'd1);
    add_eval(17'h1ffff);
    foreach (cfgs[k]) begin
      add_cfg(cfgs[k]);
      add_eval(rand_t());
    end
    // random segments, each under its own point count
    for (int s = 0; s < 12; s++) begin
      add_cfg((s == 0) ? 16 : $urandom_range(0, 31));
      for (int i = 0; i < 145; i++) begin
        if ($urandom_range(0, 99) < 35)
          add_load($urandom_range(0, 15), rand_coord(), rand_coord(), rand_coord());
        else
          add_eval(rand_t());
      end
    end
    fill_done = 1;
  end

  // driver: issues requests, config writes and drain pauses
  always @(posedge clk) begin
    logic n_start, n_we;
    int idle_pct;
    n_start = start;
    n_we = 1'b0;
    if (!rst) begin
      if (start && !busy) begin
        if (cur_job.op == OP_LOAD)
          ctrl_pts[cur_job.idx] = cur_job.pt;
        else
          curve_q = {curve_q, eval_curve(cur_job.t)};
        issued++;
        n_start = 1'b0;
      end
      if (!n_start) begin
        idle_pct = (issued < total_reqs / 3) ? 11 :
                   (issued < 2 * total_reqs / 3) ? 87 : 0;
        if (settle > 0) begin
          settle--;
        end else if (job_q.size() > 0) begin
          case (job_q[0].kind)
            K_DRAIN: begin
              if (curve_q.size() == 0 && !busy && !start) begin
                settle = SETTLE_CYCLES;
                void'(job_q.pop_front());
              end
            end
            K_CFG: begin
              n_we = 1'b1;
              cfg_data <= job_q[0].cnt;
              pt_count = job_q[0].cnt;
              void'(job_q.pop_front());
            end
            default: begin
              if ($urandom_range(0, 99) >= idle_pct) begin
                cur_job = job_q.pop_front();
                n_start = 1'b1;
                opcode <= cur_job.op;
                point_index <= cur_job.idx;
                coord_x <= cur_job.pt.x;
                coord_y <= cur_job.pt.y;
                coord_z <= cur_job.pt.z;
                param_t <= cur_job.t;
              end
            end
          endcase
        end
      end
    end
    start <= n_start;
    cfg_we <= n_we;
  end

  // monitor: compare each strobed point with the oldest prediction
  always @(posedge clk) begin
    point_t want;
    if (!rst && done) begin
      if (curve_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result x=%h y=%h z=%h", out_x, out_y, out_z);
      end else begin
        want = curve_q.pop_front();
        if (want.x !== out_x || want.y !== out_y || want.z !== out_z) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp x=%h y=%h z=%h got x=%h y=%h z=%h",
                     want.x, want.y, want.z, out_x, out_y, out_z);
        end
      end
    end
  end

  // end of run
  initial begin
    wait (fill_done);
    @(posedge clk);
    while (job_q.size() > 0 || start || curve_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && curve_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

// ----- files.f -----
rtl/bdc_pkg.sv
rtl/bdc_lerp.sv
rtl/bdc_cell.sv
rtl/bezier_de_casteljau_eval.sv
rtl/bdc_checker.sv
tb/tb.sv
